### rtl/krrl_pkg.sv
// ----------------------------------------------------------------------------
// krrl_pkg: shared types and constants of the keyed request rate limiter
// Opcodes, level codes, cell token control and controller states.
// ----------------------------------------------------------------------------
package krrl_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int COUNT_BITS_DEF    = 32;

    // Number of cells in the chain; must be a power of two
    localparam int CELL_COUNT = 8;
    localparam int CELL_W     = 3;

    localparam int KEY_W          = 64;
    localparam int LIMIT_W        = 30;
    localparam int RESULT_COUNT_W = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 30'd100;

    localparam logic [1:0] LEVEL_NONE        = 2'd0;
    localparam logic [1:0] LEVEL_LIMITED     = 2'd1;
    localparam logic [1:0] LEVEL_QUARANTINED = 2'd2;

    typedef enum logic [1:0] {
        OP_REQUEST = 2'd0,
        OP_QUERY   = 2'd1,
        OP_TICK    = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        CELL_REQUEST = 2'd0,
        CELL_QUERY   = 2'd1,
        CELL_TICK    = 2'd2,
        CELL_INSERT  = 2'd3
    } cell_op_t;

    // Control part of a token travelling down the cell chain
    typedef struct packed {
        logic                  valid;
        cell_op_t              op;
        logic                  last;
        logic [CELL_COUNT-1:0] live;
        logic                  hit;
        logic [1:0]            level;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_SCAN     = 3'd1,
        ST_DRAIN    = 3'd2,
        ST_DECIDE   = 3'd3,
        ST_INS_WAIT = 3'd4,
        ST_FINISH   = 3'd5
    } state_t;

endpackage

### rtl/keyed_request_rate_limiter_unit.sv
// ----------------------------------------------------------------------------
// keyed_request_rate_limiter_unit: per-client request policer
// Table of client keys with request counters and levels, held in a chain of
// cells; a controller scans, inserts and returns one result beat per item.
// ----------------------------------------------------------------------------
// The table is split over a chain of CELL_COUNT (8) cells. Entry e lives in
// cell e mod 8 at row e / 8 of that cell's bank. Every request, query and
// tick sends one token per occupied row down the chain, one row per cycle;
// each cell handles a token as a bank read, then a compare, update and write
// back. A request for a new key sends an insert token after the scan. On an
// empty table, or for the unused opcode, no scan runs and the controller
// goes straight to its decision; a first insert still sends its token. The
// number of occupied rows and the depth of the chain set how long an item
// takes. One item is worked on at a time; the next is accepted while the
// previous result still waits on the output. The user must write
// request_limit through cfg_we and cfg_wdata only while the block is idle;
// the block itself does not enforce this. There is no clearing pass: only
// the occupied entries are ever examined.
// ----------------------------------------------------------------------------
module keyed_request_rate_limiter_unit #(
    parameter int TABLE_ENTRIES = krrl_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = krrl_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [krrl_pkg::LIMIT_W-1:0]        cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          opcode,
    input  logic [krrl_pkg::KEY_W-1:0]          client_key,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                found,
    output logic [1:0]                          level,
    output logic                                table_full,
    output logic [krrl_pkg::RESULT_COUNT_W-1:0] request_count
);
    import krrl_pkg::*;

    localparam int BANK_DEPTH = (TABLE_ENTRIES + CELL_COUNT - 1) / CELL_COUNT;
    localparam int ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int ROWC_W     = $clog2(BANK_DEPTH + 1);
    localparam int EC_W       = $clog2(TABLE_ENTRIES + 1);

    // Controller state
    state_t                state_reg,       state_next;
    logic [LIMIT_W-1:0]    limit_reg,       limit_next;
    logic [EC_W-1:0]       entry_count_reg, entry_count_next;
    logic [1:0]            op_reg,          op_next;
    logic [KEY_W-1:0]      key_reg,         key_next;
    logic [ROWC_W-1:0]     row_reg,         row_next;
    logic                  hit_reg,         hit_next;
    logic [1:0]            acc_level_reg,   acc_level_next;
    logic [COUNT_BITS-1:0] acc_count_reg,   acc_count_next;
    logic                  full_reg,        full_next;

    // Output beat register
    logic                      out_valid_reg,  out_valid_next;
    logic                      found_reg,      found_next;
    logic [1:0]                level_reg,      level_next;
    logic                      tfull_reg,      tfull_next;
    logic [RESULT_COUNT_W-1:0] count_out_reg,  count_out_next;

    // Cell chain links: link 0 is the issue point, the last link the exit
    cell_ctrl_t            link_ctrl  [CELL_COUNT+1];
    logic [KEY_W-1:0]      link_key   [CELL_COUNT+1];
    logic [ROW_W-1:0]      link_row   [CELL_COUNT+1];
    logic [COUNT_BITS-1:0] link_count [CELL_COUNT+1];

    cell_ctrl_t            issue_ctrl;
    logic [ROW_W-1:0]      issue_row;
    logic [ROWC_W-1:0]     full_rows;
    logic [ROWC_W-1:0]     scan_rows;
    logic [CELL_W-1:0]     partial;
    logic                  exit_last;
    cell_op_t              scan_op;

    assign link_ctrl[0]  = issue_ctrl;
    assign link_key[0]   = key_reg;
    assign link_row[0]   = issue_row;
    assign link_count[0] = '0;

    for (genvar g = 0; g < CELL_COUNT; g++)
    begin : g_cell
        krrl_cell #(
            .CELL_INDEX    (g),
            .TABLE_ENTRIES (TABLE_ENTRIES),
            .COUNT_BITS    (COUNT_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .limit     (limit_reg),
            .in_ctrl   (link_ctrl[g]),
            .in_key    (link_key[g]),
            .in_row    (link_row[g]),
            .in_count  (link_count[g]),
            .out_ctrl  (link_ctrl[g+1]),
            .out_key   (link_key[g+1]),
            .out_row   (link_row[g+1]),
            .out_count (link_count[g+1])
        );
    end

    // Row geometry of the occupied part of the table
    assign full_rows = ROWC_W'(entry_count_reg >> CELL_W);
    assign partial   = CELL_W'(entry_count_reg);
    assign scan_rows = full_rows + ROWC_W'(partial != '0);
    assign exit_last = link_ctrl[CELL_COUNT].valid && link_ctrl[CELL_COUNT].last;

    always_comb
    begin
        case (op_reg)
            OP_REQUEST: scan_op = CELL_REQUEST;
            OP_QUERY:   scan_op = CELL_QUERY;
            default:    scan_op = CELL_TICK;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        limit_next       = limit_reg;
        entry_count_next = entry_count_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        row_next         = row_reg;
        hit_next         = hit_reg;
        acc_level_next   = acc_level_reg;
        acc_count_next   = acc_count_reg;
        full_next        = full_reg;
        out_valid_next   = out_valid_reg;
        found_next       = found_reg;
        level_next       = level_reg;
        tfull_next       = tfull_reg;
        count_out_next   = count_out_reg;

        in_ready   = 1'b0;
        issue_ctrl = '0;
        issue_row  = ROW_W'(row_reg);

        if (cfg_we)
        begin
            limit_next = cfg_wdata;
        end

        // Drop the result beat once it is taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Collect the matching entry from tokens leaving the chain
        if (link_ctrl[CELL_COUNT].valid && link_ctrl[CELL_COUNT].hit)
        begin
            hit_next       = 1'b1;
            acc_level_next = link_ctrl[CELL_COUNT].level;
            acc_count_next = link_count[CELL_COUNT];
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next        = opcode;
                    key_next       = client_key;
                    row_next       = '0;
                    hit_next       = 1'b0;
                    acc_level_next = LEVEL_NONE;
                    acc_count_next = '0;
                    full_next      = 1'b0;
                    if ((opcode inside {OP_REQUEST, OP_QUERY, OP_TICK})
                        && (entry_count_reg != '0))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_SCAN:
            begin
                // Issue one token per occupied row
                issue_ctrl.valid = 1'b1;
                issue_ctrl.op    = scan_op;
                issue_ctrl.last  = (row_reg == scan_rows - ROWC_W'(1));
                for (int k = 0; k < CELL_COUNT; k++)
                begin
                    issue_ctrl.live[k] = (row_reg < full_rows) || (CELL_W'(k) < partial);
                end
                row_next = row_reg + ROWC_W'(1);
                if (issue_ctrl.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (exit_last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if ((op_reg == OP_REQUEST) && !hit_reg)
                begin
                    if (entry_count_reg == EC_W'(TABLE_ENTRIES))
                    begin
                        full_next  = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        // Append the new key at the next free entry
                        issue_ctrl.valid = 1'b1;
                        issue_ctrl.op    = CELL_INSERT;
                        issue_ctrl.last  = 1'b1;
                        for (int k = 0; k < CELL_COUNT; k++)
                        begin
                            issue_ctrl.live[k] = (CELL_W'(k) == partial);
                        end
                        issue_row        = ROW_W'(full_rows);
                        entry_count_next = entry_count_reg + EC_W'(1);
                        state_next       = ST_INS_WAIT;
                    end
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_INS_WAIT:
            begin
                if (exit_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    found_next     = hit_reg;
                    level_next     = acc_level_reg;
                    tfull_next     = full_reg;
                    count_out_next = RESULT_COUNT_W'(acc_count_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            limit_reg       <= LIMIT_RESET;
            entry_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            limit_reg       <= limit_next;
            entry_count_reg <= entry_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        row_reg       <= row_next;
        hit_reg       <= hit_next;
        acc_level_reg <= acc_level_next;
        acc_count_reg <= acc_count_next;
        full_reg      <= full_next;
        found_reg     <= found_next;
        level_reg     <= level_next;
        tfull_reg     <= tfull_next;
        count_out_reg <= count_out_next;
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign level         = level_reg;
    assign table_full    = tfull_reg;
    assign request_count = count_out_reg;

endmodule

### rtl/krrl_cell.sv
// ----------------------------------------------------------------------------
// krrl_cell: one cell of the client table chain
// Holds one bank of table rows; matches, counts, grades or inserts the entry
// of its lane in the row a token names, then hands the token on.
// ----------------------------------------------------------------------------
module krrl_cell #(
    parameter int CELL_INDEX    = 0,
    parameter int TABLE_ENTRIES = krrl_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = krrl_pkg::COUNT_BITS_DEF,
    localparam int BANK_DEPTH   = (TABLE_ENTRIES + krrl_pkg::CELL_COUNT - 1)
                                  / krrl_pkg::CELL_COUNT,
    localparam int ROW_W        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [krrl_pkg::LIMIT_W-1:0] limit,
    input  krrl_pkg::cell_ctrl_t         in_ctrl,
    input  logic [krrl_pkg::KEY_W-1:0]   in_key,
    input  logic [ROW_W-1:0]             in_row,
    input  logic [COUNT_BITS-1:0]        in_count,
    output krrl_pkg::cell_ctrl_t         out_ctrl,
    output logic [krrl_pkg::KEY_W-1:0]   out_key,
    output logic [ROW_W-1:0]             out_row,
    output logic [COUNT_BITS-1:0]        out_count
);
    import krrl_pkg::*;

    localparam int CMP_W = (COUNT_BITS > LIMIT_W + 1) ? COUNT_BITS : LIMIT_W + 1;

    logic [KEY_W-1:0]      key_mem [BANK_DEPTH];
    logic [COUNT_BITS-1:0] cnt_mem [BANK_DEPTH];
    logic [1:0]            lvl_mem [BANK_DEPTH];

    logic [KEY_W-1:0]      rd_key_reg;
    logic [COUNT_BITS-1:0] rd_cnt_reg;
    logic [1:0]            rd_lvl_reg;

    cell_ctrl_t            s1_ctrl_reg;
    logic [KEY_W-1:0]      s1_key_reg;
    logic [ROW_W-1:0]      s1_row_reg;
    logic [COUNT_BITS-1:0] s1_count_reg;

    cell_ctrl_t            out_ctrl_reg;
    cell_ctrl_t            out_ctrl_next;
    logic [KEY_W-1:0]      out_key_reg;
    logic [ROW_W-1:0]      out_row_reg;
    logic [COUNT_BITS-1:0] out_count_reg;
    logic [COUNT_BITS-1:0] out_count_next;

    logic                  live;
    logic                  key_hit;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [CMP_W-1:0]      cnt_ext;
    logic [CMP_W-1:0]      lim_ext;
    logic [CMP_W-1:0]      twice_ext;
    logic                  wr_en;
    logic [KEY_W-1:0]      wr_key;
    logic [COUNT_BITS-1:0] wr_cnt;
    logic [1:0]            wr_lvl;

    // Bank: read at the arriving row, write back the row held in stage one
    always_ff @(posedge clk)
    begin
        rd_key_reg <= key_mem[in_row];
        rd_cnt_reg <= cnt_mem[in_row];
        rd_lvl_reg <= lvl_mem[in_row];
        if (wr_en)
        begin
            key_mem[s1_row_reg] <= wr_key;
            cnt_mem[s1_row_reg] <= wr_cnt;
            lvl_mem[s1_row_reg] <= wr_lvl;
        end
    end

    always_comb
    begin
        live      = s1_ctrl_reg.valid && s1_ctrl_reg.live[CELL_INDEX];
        key_hit   = live && (rd_key_reg == s1_key_reg)
                    && ((s1_ctrl_reg.op == CELL_REQUEST) || (s1_ctrl_reg.op == CELL_QUERY));
        cnt_inc   = (rd_cnt_reg == '1) ? rd_cnt_reg : rd_cnt_reg + COUNT_BITS'(1);
        cnt_ext   = CMP_W'(rd_cnt_reg);
        lim_ext   = CMP_W'(limit);
        twice_ext = CMP_W'({limit, 1'b0});

        wr_en  = 1'b0;
        wr_key = rd_key_reg;
        wr_cnt = rd_cnt_reg;
        wr_lvl = rd_lvl_reg;

        out_ctrl_next  = s1_ctrl_reg;
        out_count_next = s1_count_reg;

        case (s1_ctrl_reg.op)
            CELL_REQUEST:
            begin
                if (key_hit)
                begin
                    wr_en = 1'b1;
                    wr_cnt = cnt_inc;
                    out_ctrl_next.hit   = 1'b1;
                    out_ctrl_next.level = rd_lvl_reg;
                    out_count_next      = cnt_inc;
                end
            end
            CELL_QUERY:
            begin
                if (key_hit)
                begin
                    out_ctrl_next.hit   = 1'b1;
                    out_ctrl_next.level = rd_lvl_reg;
                    out_count_next      = rd_cnt_reg;
                end
            end
            CELL_TICK:
            begin
                wr_en = live;
                if (cnt_ext < lim_ext)
                begin
                    wr_lvl = LEVEL_NONE;
                    wr_cnt = '0;
                end
                else if (cnt_ext >= twice_ext)
                begin
                    // twice the limit fits here, since the count reached it
                    wr_lvl = LEVEL_QUARANTINED;
                    wr_cnt = COUNT_BITS'(twice_ext);
                end
                else
                begin
                    wr_lvl = LEVEL_LIMITED;
                    wr_cnt = rd_cnt_reg - COUNT_BITS'(1);
                end
            end
            CELL_INSERT:
            begin
                wr_en  = live;
                wr_key = s1_key_reg;
                wr_cnt = '0;
                wr_lvl = LEVEL_NONE;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg  <= '0;
            out_ctrl_reg <= '0;
        end
        else
        begin
            s1_ctrl_reg  <= in_ctrl;
            out_ctrl_reg <= out_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_key_reg    <= in_key;
        s1_row_reg    <= in_row;
        s1_count_reg  <= in_count;
        out_key_reg   <= s1_key_reg;
        out_row_reg   <= s1_row_reg;
        out_count_reg <= out_count_next;
    end

    assign out_ctrl  = out_ctrl_reg;
    assign out_key   = out_key_reg;
    assign out_row   = out_row_reg;
    assign out_count = out_count_reg;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the keyed request rate limiter
// Drives request, query, tick and unused-opcode beats with bursty timing,
// grades a shadow copy of the client table for every accepted beat and
// compares each result beat field by field. Covers the limit extremes, exact
// key matching and near-miss keys.
// ----------------------------------------------------------------------------
module tb_top;

    import krrl_pkg::*;

    localparam int          TABLE_ENTRIES  = TABLE_ENTRIES_DEF;
    localparam int          COUNT_BITS     = COUNT_BITS_DEF;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam logic [29:0] LIMIT_MAX      = 30'h3FFF_FFFF;
    localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;
    localparam int          RANDOM_PHASES  = 8;
    localparam int          PHASE_BEATS    = 90;
    // A full table scans 128 rows plus the chain depth and the insert token;
    // the watchdog limit is set well above that
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          TAIL_CYCLES    = 400;

    // Expected contents of one result beat
    typedef struct packed {
        logic        hit;
        logic [1:0]  grade;
        logic        full;
        logic [31:0] count;
    } result_t;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      cfg_we        = 1'b0;
    logic [LIMIT_W-1:0]        cfg_wdata     = '0;
    logic                      in_valid      = 1'b0;
    logic                      in_ready;
    logic [1:0]                opcode        = OP_REQUEST;
    logic [KEY_W-1:0]          client_key    = '0;
    logic                      out_valid;
    logic                      out_ready     = 1'b0;
    logic                      found;
    logic [1:0]                level;
    logic                      table_full;
    logic [RESULT_COUNT_W-1:0] request_count;

    // Shadow of the client table and of the limit register
    logic [63:0]  shadow_keys   [TABLE_ENTRIES];
    logic [31:0]  shadow_counts [TABLE_ENTRIES];
    logic [1:0]   shadow_levels [TABLE_ENTRIES];
    int           shadow_used  = 0;
    logic [29:0]  limit_shadow = LIMIT_RESET;

    result_t      pending_results [$];
    result_t      head_result;
    logic [63:0]  hot_keys [$];
    int           error_count = 0;
    int           burst_left  = 0;
    int           idle_cycles = 0;
    int unsigned  stall_phase = 0;

    keyed_request_rate_limiter_unit #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .client_key    (client_key),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .level         (level),
        .table_full    (table_full),
        .request_count (request_count)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow table: exact-match lookup and grading
    // ------------------------------------------------------------------------
    function automatic int find_slot(input logic [63:0] key);
        for (int i = 0; i < shadow_used; i++)
            if (shadow_keys[i] == key)
                return i;
        return -1;
    endfunction

    // Apply one beat to the shadow table and return the result it must give
    function automatic result_t policer_predict(input logic [1:0] op,
                                                input logic [63:0] key);
        result_t     r;
        int          slot;
        logic [31:0] twice;
        r     = '0;
        twice = {1'b0, limit_shadow, 1'b0};
        case (op)
            OP_REQUEST:
            begin
                slot = find_slot(key);
                if (slot >= 0)
                begin
                    // Saturate rather than wrap
                    if (shadow_counts[slot] != COUNT_MAX)
                        shadow_counts[slot] = shadow_counts[slot] + 1;
                    r.hit   = 1'b1;
                    r.grade = shadow_levels[slot];
                    r.count = shadow_counts[slot];
                end
                else if (shadow_used >= TABLE_ENTRIES)
                    r.full = 1'b1;
                else
                begin
                    // New client: store with a clean counter, report nothing
                    shadow_keys[shadow_used]   = key;
                    shadow_counts[shadow_used] = '0;
                    shadow_levels[shadow_used] = LEVEL_NONE;
                    shadow_used++;
                end
            end
            OP_QUERY:
            begin
                slot = find_slot(key);
                if (slot >= 0)
                begin
                    r.hit   = 1'b1;
                    r.grade = shadow_levels[slot];
                    r.count = shadow_counts[slot];
                end
            end
            OP_TICK:
            begin
                // Regrade every stored client; a zero limit quarantines all
                for (int i = 0; i < shadow_used; i++)
                begin
                    if (shadow_counts[i] < {2'b0, limit_shadow})
                    begin
                        shadow_levels[i] = LEVEL_NONE;
                        shadow_counts[i] = '0;
                    end
                    else if (shadow_counts[i] >= twice)
                    begin
                        shadow_levels[i] = LEVEL_QUARANTINED;
                        shadow_counts[i] = twice;
                    end
                    else
                    begin
                        shadow_levels[i] = LEVEL_LIMITED;
                        shadow_counts[i] = shadow_counts[i] - 1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: bursts of beats separated by random gaps. Valid is only ever
    // lowered at the start of a gap, so it never drops and rises in one step.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [1:0] op, input logic [63:0] key);
        int gap;
        if (burst_left == 0)
        begin
            // One burst in three follows straight on with no gap at all
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        client_key <= key;
        // Hold the beat until the block takes it
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(policer_predict(op, key));
        burst_left--;
    endtask

    // Drop valid and wait until every outstanding result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Write request_limit while the block is idle
    task automatic write_limit(input logic [29:0] value);
        wait_drained();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we       <= 1'b0;
        limit_shadow = value;
    endtask

    function automatic logic [63:0] random_key();
        return {$urandom, $urandom};
    endfunction

    // One random beat, mostly well-formed traffic on the hot keys so that
    // counters climb past the limit between ticks
    task automatic random_item();
        int          pick;
        logic [63:0] hot;
        pick = $urandom_range(0, 99);
        // Favour the first hot key so that one client runs well ahead
        if ($urandom_range(0, 2) == 0)
            hot = hot_keys[0];
        else
            hot = hot_keys[$urandom_range(0, hot_keys.size() - 1)];
        if (pick < 55)
            send_item(OP_REQUEST, hot);
        else if (pick < 68)
            send_item(OP_QUERY, hot);
        else if (pick < 73)
            // One flipped bit must never match
            send_item(OP_QUERY, hot ^ (64'd1 << $urandom_range(0, 63)));
        else if (pick < 78)
            send_item(OP_QUERY, random_key());
        else if (pick < 83)
            send_item(OP_REQUEST, random_key());
        else if (pick < 91)
            send_item(OP_TICK, random_key());
        else if (pick < 96)
            send_item(OP_QUERY, shadow_keys[$urandom_range(0, shadow_used - 1)]);
        else
            send_item(OP_UNUSED, random_key());
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Every operation on an empty and lightly filled table at the reset limit
    task automatic test_basic_ops();
        send_item(OP_QUERY,   64'h0);
        send_item(OP_REQUEST, 64'h0);
        send_item(OP_REQUEST, 64'h0);
        send_item(OP_REQUEST, '1);
        send_item(OP_QUERY,   '1);
        send_item(OP_QUERY,   {63'h7FFF_FFFF_FFFF_FFFF, 1'b0});
        send_item(OP_UNUSED,  64'h0);
        send_item(OP_QUERY,   64'h0);
        send_item(OP_REQUEST, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(OP_REQUEST, 64'h5555_5555_5555_5555);
        send_item(OP_REQUEST, 64'h8000_0000_0000_0000);
        send_item(OP_TICK,    '1);
        send_item(OP_QUERY,   64'h0);
    endtask

    // Grading at a limit of one, at zero and at the largest limit
    task automatic test_grading_extremes();
        write_limit(30'd1);
        send_item(OP_REQUEST, 64'h0);
        send_item(OP_REQUEST, 64'h0);
        send_item(OP_REQUEST, '1);
        send_item(OP_TICK,    64'h0);
        send_item(OP_QUERY,   64'h0);
        send_item(OP_QUERY,   '1);
        send_item(OP_QUERY,   64'hAAAA_AAAA_AAAA_AAAA);
        send_item(OP_REQUEST, 64'h0);
        // A zero limit quarantines every client with a cleared counter
        write_limit(30'd0);
        send_item(OP_TICK,    64'h0);
        send_item(OP_QUERY,   64'h5555_5555_5555_5555);
        write_limit(LIMIT_MAX);
        send_item(OP_REQUEST, '1);
        send_item(OP_TICK,    64'h0);
        send_item(OP_QUERY,   '1);
    endtask

    // Random traffic over several limit settings, a fresh hot set each time
    task automatic test_random_traffic();
        logic [29:0] phase_limits [RANDOM_PHASES];
        phase_limits = '{30'd2, 30'd3, 30'd5, 30'd1, 30'd8, LIMIT_MAX, 30'd4,
                         LIMIT_RESET};
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_limit(phase_limits[p]);
            hot_keys.delete();
            repeat ($urandom_range(2, 4))
                hot_keys.push_back(random_key());
            repeat (PHASE_BEATS)
                random_item();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_ops();
        test_grading_extremes();
        test_random_traffic();
        wait_drained();
        // Let any stray result beat show up before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t ns: %0d result beats never arrived", $time,
                     pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: cycle through four stall patterns, one of them never stalls
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1;
        case (stall_phase[9:8])
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= $urandom_range(0, 1);
            2'd2:    out_ready <= (stall_phase[2:0] == 3'd0);
            default: out_ready <= ((stall_phase % 13) >= 5);
        endcase
    end

    // ------------------------------------------------------------------------
    // Checker: compare each result beat with the oldest expectation
    // ------------------------------------------------------------------------
    task automatic compare_field(input string field_name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h",
                     $time, field_name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: result beat with nothing expected", $time);
                error_count++;
            end
            else
            begin
                head_result = pending_results.pop_front();
                compare_field("found",         head_result.hit,   found);
                compare_field("level",         head_result.grade, level);
                compare_field("table_full",    head_result.full,  table_full);
                compare_field("request_count", head_result.count, request_count);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no beat moves on either side for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

endmodule
